### design/mps_pkg.sv
// Shared types and constants for the masked pattern scanner.
package mps_pkg;

  localparam int ADDR_W    = 32;
  localparam int COUNT_W   = 32;
  localparam int SKIP_W    = 16;
  localparam int MATCH_W   = 17;
  localparam int PLEN_W    = 5;
  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 3;
  localparam int PAT_BYTES = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ADDRESS       = 3'd0,
    CFG_SCAN_LIMIT         = 3'd1,
    CFG_SKIP_COUNT         = 3'd2,
    CFG_PATTERN_BYTES_LOW  = 3'd3,
    CFG_PATTERN_BYTES_HIGH = 3'd4,
    CFG_CARE_MASK          = 3'd5,
    CFG_PATTERN_LENGTH     = 3'd6
  } cfg_reg_t;

endpackage

### design/masked_pattern_scanner.sv
// Masked byte signature scanner over a stream of memory bytes.
//
// The input channel carries one memory byte per item, in address order, with
// in_scan_start marking position zero of a new scan. Each item is captured in
// an input register and handled in the next cycle: the window compare, the
// counters and the result all resolve combinationally in that cycle, so the block
// takes a new item every cycle unless a result waits on a stalled receiver.
// A result item (found or not found) is registered from the item that ended
// the scan. Items that end no scan produce nothing; after a result the block
// drops bytes until the next item with in_scan_start set.
// The configuration port writes one register per cycle with no wait.
// If the receiver stalls, the result is held in the output register; items
// that produce no result keep flowing, and an item that would produce a result
// waits in the input register, which then holds in_ready low.
// Reset (synchronous, active low) loads the register reset values, empties
// both stages and leaves the scanner idle until a scan start.
module masked_pattern_scanner
  import mps_pkg::*;
#(
  parameter int PATTERN_MAX = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte_value,
  input  logic                 in_scan_start,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_found,
  output logic [ADDR_W-1:0]    out_match_address,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int LW = ($clog2(PATTERN_MAX + 1) > PLEN_W) ? $clog2(PATTERN_MAX + 1) : PLEN_W;
  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int WD = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
  localparam int CK = (PATTERN_MAX < PAT_BYTES) ? PATTERN_MAX : PAT_BYTES;

  // Configuration registers
  logic [ADDR_W-1:0]    base_address_r;
  logic [COUNT_W-1:0]   scan_limit_r;
  logic [SKIP_W-1:0]    skip_count_r;
  logic [8*PAT_BYTES-1:0] pattern_r;
  logic [PAT_BYTES-1:0] care_mask_r;
  logic [PLEN_W-1:0]    pattern_length_r;

  // Input stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;

  // Scan state
  logic [7:0]         win_r [WD];
  logic [7:0]         win_base [WD];
  logic [COUNT_W-1:0] seen_r, seen_base, seen_nxt;
  logic [MATCH_W-1:0] matches_r, matches_base, matches_nxt;
  logic               finished_r, finished_base, finished_nxt;

  logic [7:0]         cur [PATTERN_MAX];
  logic [LW-1:0]      pl, len, idx;
  logic [COUNT_W-1:0] pos;
  logic               active, checked, match, report_hit, report_miss, result_hit;
  logic               s1_fire;

  // Output register
  logic              out_valid_r;
  logic              out_found_r;
  logic [ADDR_W-1:0] out_match_address_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_address_r   <= '0;
      scan_limit_r     <= '0;
      skip_count_r     <= '0;
      pattern_r        <= '0;
      care_mask_r      <= '0;
      pattern_length_r <= PLEN_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_ADDRESS:       base_address_r   <= cfg_data[ADDR_W-1:0];
        CFG_SCAN_LIMIT:         scan_limit_r     <= cfg_data[COUNT_W-1:0];
        CFG_SKIP_COUNT:         skip_count_r     <= cfg_data[SKIP_W-1:0];
        CFG_PATTERN_BYTES_LOW:  pattern_r[63:0]  <= cfg_data;
        CFG_PATTERN_BYTES_HIGH: pattern_r[127:64] <= cfg_data;
        CFG_CARE_MASK:          care_mask_r      <= cfg_data[PAT_BYTES-1:0];
        CFG_PATTERN_LENGTH:     pattern_length_r <= cfg_data[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // A scan start wipes the state before the byte is handled.
  always_comb begin
    seen_base     = s1_start_r ? '0 : seen_r;
    matches_base  = s1_start_r ? '0 : matches_r;
    finished_base = s1_start_r ? 1'b0 : finished_r;
    for (int i = 0; i < WD; i++) begin
      win_base[i] = s1_start_r ? 8'h00 : win_r[i];
    end
    cur[0] = s1_byte_r;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      cur[j] = win_base[j-1];
    end
  end

  always_comb begin
    pl = LW'(pattern_length_r);
    if (pl == '0) begin
      len = LW'(1);
    end else if (pl > LW'(PATTERN_MAX)) begin
      len = LW'(PATTERN_MAX);
    end else begin
      len = pl;
    end
  end

  // Pattern byte k lines up with the byte len-1-k positions back.
  always_comb begin
    match = 1'b1;
    idx   = '0;
    for (int k = 0; k < CK; k++) begin
      idx = len - LW'(1) - LW'(k);
      if (LW'(k) < len && care_mask_r[k] &&
          cur[idx[IW-1:0]] != pattern_r[8*k +: 8]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    active       = s1_valid_r && !finished_base;
    seen_nxt     = (seen_base == '1) ? seen_base : seen_base + COUNT_W'(1);
    checked      = seen_nxt >= COUNT_W'(len);
    pos          = seen_nxt - COUNT_W'(len);
    matches_nxt  = (checked && match) ? matches_base + MATCH_W'(1) : matches_base;
    report_hit   = checked && match && (matches_nxt > MATCH_W'(skip_count_r));
    report_miss  = checked && !match &&
                   ({1'b0, pos} + (COUNT_W+1)'(1) >= {1'b0, scan_limit_r});
    result_hit   = active && (report_hit || report_miss);
    finished_nxt = finished_base || report_hit || report_miss;
  end

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready || !result_hit);
  assign in_ready = !s1_valid_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r  <= in_byte_value;
      s1_start_r <= in_scan_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r     <= '0;
      matches_r  <= '0;
      finished_r <= 1'b1;
      for (int i = 0; i < WD; i++) begin
        win_r[i] <= 8'h00;
      end
    end else if (s1_fire) begin
      if (finished_base) begin
        seen_r     <= seen_base;
        matches_r  <= matches_base;
        finished_r <= finished_base;
        win_r      <= win_base;
      end else begin
        seen_r     <= seen_nxt;
        matches_r  <= matches_nxt;
        finished_r <= finished_nxt;
        win_r[0]   <= s1_byte_r;
        for (int i = 1; i < WD; i++) begin
          win_r[i] <= win_base[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && result_hit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && result_hit) begin
      out_found_r         <= report_hit;
      out_match_address_r <= report_hit ? base_address_r + pos : '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_match_address = out_match_address_r;

endmodule

### design/mps_checker.sv
// Port-level checks for the masked pattern scanner, bound to the top level.
module mps_checker
  import mps_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_found,
  input logic [ADDR_W-1:0] out_match_address
);

  // A stalled result must hold.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) &&
                                $stable(out_match_address))
    else $error("result changed while stalled");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_match_address == '0)
    else $error("not-found result carries an address");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // A new result must trace back to an accepted input item, through the input and output registers.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching input item");

endmodule

bind masked_pattern_scanner mps_checker u_mps_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_found         (out_found),
  .out_match_address (out_match_address)
);
